### src/gne_pkg.sv
// Shared types, constants and move tables for the grid neighbor edge expander.
// Used by every module of the block and by the bench.
`default_nettype none

package gne_pkg;

  localparam int COORD_W     = 11;  // holds coordinates up to 256 and -1 as a wrapped value
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 9;
  localparam int EDGE_W      = 19;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [EDGE_W-1:0] COST_MAX = 19'h7FFFF;

  // sqrt(2) with 40 fraction bits, 0x16A09E667F4, split into two halves
  localparam logic [20:0] SQRT2_HI = 21'h16A09E;
  localparam logic [19:0] SQRT2_LO = 20'h667F4;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_SUCC  = 2'd1,
    MODE_PRED  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH  = 3'd0,
    CFG_MAP_HEIGHT = 3'd1,
    CFG_THRESHOLD  = 3'd2,
    CFG_GOAL_X     = 3'd3,
    CFG_GOAL_Y     = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_EXPAND,
    CMD_EMPTY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic       succ;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] cost;
  } cmd_t;

  // Effective map size (already clamped) and the other settings.
  typedef struct packed {
    logic [8:0] width;
    logic [8:0] height;
    logic [7:0] threshold;
    logic [7:0] goal_x;
    logic [7:0] goal_y;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_PICK,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_SEND,
    ST_EMPTY
  } back_state_t;

  // 3x3 window cell k sits at (x + CELL_DX[k] - 1, y + CELL_DY[k] - 1); center is cell 4.
  localparam logic [1:0] CELL_DX [9] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
  localparam logic [1:0] CELL_DY [9] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};
  localparam logic [3:0] CENTER_CELL = 4'd4;

  // Per move: target cell, and the two orthogonal cells a diagonal cuts past.
  localparam logic [3:0] MOVE_CELL [8] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8};
  localparam logic [3:0] ORTHO_A   [8] = '{4'd3, 4'd1, 4'd5, 4'd3, 4'd5, 4'd3, 4'd7, 4'd5};
  localparam logic [3:0] ORTHO_B   [8] = '{4'd1, 4'd1, 4'd1, 4'd3, 4'd5, 4'd7, 4'd7, 4'd7};
  localparam logic [7:0] MOVE_DIAG = 8'b1010_0101;

  // Coordinate c shifted by d - 1; minus one wraps to the all-ones value.
  function automatic logic [COORD_W-1:0] cell_coord(input logic [7:0] c, input logic [1:0] d);
    return COORD_W'(c) + COORD_W'(d) - COORD_W'(1);
  endfunction

endpackage

`default_nettype wire

### src/gne_if.sv
// Valid/ready channel interfaces for the request and result streams.
// Depends on nothing but the port widths of the block.
`default_nettype none

interface gne_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] cell_x;
  logic [7:0] cell_y;
  logic [7:0] cell_cost;

  modport source (output valid, mode, cell_x, cell_y, cell_cost, input ready);
  modport sink   (input valid, mode, cell_x, cell_y, cell_cost, output ready);
endinterface

interface gne_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  neighbor_x;
  logic [7:0]  neighbor_y;
  logic [18:0] edge_cost;
  logic [2:0]  move_index;
  logic        item_valid;
  logic        last_of_run;

  modport source (output valid, neighbor_x, neighbor_y, edge_cost, move_index, item_valid,
                  last_of_run, input ready);
  modport sink   (input valid, neighbor_x, neighbor_y, edge_cost, move_index, item_valid,
                  last_of_run, output ready);
endinterface

`default_nettype wire

### src/grid_neighbor_edge_expander.sv
// Top level of the grid neighbor edge expander: configuration registers and
// the front end, command queue and back end. Depends on gne_pkg and gne_if.
`default_nettype none

// Usage
// The block holds a cost grid of MAP_DIM x MAP_DIM 8-bit cells. Requests arrive
// on the req channel and results leave on the rsp channel; both use valid/ready
// and a transfer happens when both are high at a rising edge of clk.
// A write request (mode 0) stores one cell and answers with one empty result
// (item_valid 0, last_of_run 1). An expand request (mode 1 successors, mode 2
// predecessors) yields one result per reachable king-move neighbor, in fixed
// move order, with last_of_run marking the final one; an expansion with no
// neighbor, an unused mode or an invalid cell gives one empty result.
// An expansion reads the 3x3 window from the grid memory through its
// registered read port, one cell per cycle, evaluates all moves together,
// then passes each neighbor through the pick, high multiply, low multiply and
// send states for the edge-cost multiplies and result load. The back end
// finishes one request before it takes the next.
// A two-entry command queue lets the front end take new requests while the
// back end works. When the receiver stalls, the result register holds and the
// back end waits; the queue then fills and req.ready drops.
// Reset (synchronous, active high) clears control state and restores the
// registers to width 256, height 256, threshold 1, goal (0,0). Grid cells are
// undefined until written. The user must write configuration through cfg_we,
// cfg_index and cfg_data only while the block is idle; the block does not check.

module grid_neighbor_edge_expander import gne_pkg::*; #(
  parameter int MAP_DIM    = 256,
  parameter int COST_SCALE = 1000
) (
  input  logic                  clk,
  input  logic                  rst,
  gne_req_if.sink               req,
  gne_rsp_if.source             rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DIM_CAP = (MAP_DIM < 256) ? MAP_DIM : 256;

  logic [8:0] map_width;
  logic [8:0] map_height;
  logic [7:0] obstacle_threshold;
  logic [7:0] goal_x;
  logic [7:0] goal_y;
  cfg_t       cfg;

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;
  cmd_t       q_in;
  cmd_t       q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width          <= 9'd256;
      map_height         <= 9'd256;
      obstacle_threshold <= 8'd1;
      goal_x             <= 8'd0;
      goal_y             <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAP_WIDTH:  map_width          <= cfg_data;
        CFG_MAP_HEIGHT: map_height         <= cfg_data;
        CFG_THRESHOLD:  obstacle_threshold <= cfg_data[7:0];
        CFG_GOAL_X:     goal_x             <= cfg_data[7:0];
        CFG_GOAL_Y:     goal_y             <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // The map in use never extends past the storage or past 256 cells.
  assign cfg.width     = (map_width > 9'(DIM_CAP)) ? 9'(DIM_CAP) : map_width;
  assign cfg.height    = (map_height > 9'(DIM_CAP)) ? 9'(DIM_CAP) : map_height;
  assign cfg.threshold = obstacle_threshold;
  assign cfg.goal_x    = goal_x;
  assign cfg.goal_y    = goal_y;

  gne_front #(.MAP_DIM(MAP_DIM)) u_front (
    .req    (req),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  gne_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  gne_back #(.MAP_DIM(MAP_DIM), .COST_SCALE(COST_SCALE)) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

  // An empty result always closes its run and carries zero fields.
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.item_valid) |-> (rsp.last_of_run && rsp.edge_cost == '0
      && rsp.neighbor_x == '0 && rsp.neighbor_y == '0 && rsp.move_index == '0))
    else $error("empty result with nonzero fields");

  // A neighbor result always has a nonzero cost and lies inside the map.
  assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.item_valid) |-> (rsp.edge_cost != '0
      && {1'b0, rsp.neighbor_x} < cfg.width && {1'b0, rsp.neighbor_y} < cfg.height))
    else $error("neighbor result out of map or with zero cost");

  // The back end never takes a command from an empty queue.
  assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue read while empty");

endmodule

`default_nettype wire

### src/gne_front.sv
// Front end: accepts request transfers and classifies them into commands.
// Depends on gne_pkg and gne_req_if; feeds gne_queue.
`default_nettype none

module gne_front import gne_pkg::*; #(
  parameter int MAP_DIM = 256
) (
  gne_req_if.sink    req,
  input  cfg_t       cfg,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_data
);

  logic in_store;
  logic in_map;
  logic at_goal;

  assign in_store = (COORD_W'(req.cell_x) < COORD_W'(MAP_DIM))
                 && (COORD_W'(req.cell_y) < COORD_W'(MAP_DIM));
  assign in_map   = ({1'b0, req.cell_x} < cfg.width) && ({1'b0, req.cell_y} < cfg.height);
  assign at_goal  = (req.cell_x == cfg.goal_x) && (req.cell_y == cfg.goal_y);

  always_comb begin
    q_data.succ = 1'b0;
    q_data.x    = req.cell_x;
    q_data.y    = req.cell_y;
    q_data.cost = req.cell_cost;
    unique case (mode_t'(req.mode))
      MODE_WRITE: begin
        q_data.kind = in_store ? CMD_WRITE : CMD_EMPTY;
      end
      MODE_SUCC: begin
        q_data.succ = 1'b1;
        q_data.kind = (in_map && !at_goal) ? CMD_EXPAND : CMD_EMPTY;
      end
      MODE_PRED: begin
        q_data.kind = in_map ? CMD_EXPAND : CMD_EMPTY;
      end
      default: begin
        q_data.kind = CMD_EMPTY;
      end
    endcase
  end

  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full;

endmodule

`default_nettype wire

### src/gne_queue.sv
// Short command queue between the front end and the back end.
// Depends on gne_pkg for the command type and depth.
`default_nettype none

module gne_queue import gne_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t pop_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t            entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;

  assign full      = (count == (PW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

### src/gne_back.sv
// Back end: owns the cost grid memory, carries out writes and expansions and
// drives the result register. Depends on gne_pkg and gne_rsp_if.
`default_nettype none

module gne_back import gne_pkg::*; #(
  parameter int MAP_DIM    = 256,
  parameter int COST_SCALE = 1000
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  cmd_t        q_data,
  output logic        q_pop,
  gne_rsp_if.source   rsp
);

  localparam int AW    = $clog2(MAP_DIM * MAP_DIM);
  localparam int DEPTH = MAP_DIM * MAP_DIM;
  localparam logic [15:0] SCALE = 16'(COST_SCALE);

  back_state_t state;
  back_state_t state_next;

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic          mem_we;
  logic          rd_issue;

  cmd_t          cmd;
  logic [3:0]    rd_cnt;
  logic          cap_en;
  logic [3:0]    cap_idx;
  logic [7:0]    nb [9];

  logic [7:0]    lane_cm [8];
  logic [7:0]    lane_ok;
  logic [7:0]    mask;
  logic [7:0]    cm_r [8];

  logic [2:0]    sel;
  logic [7:0]    sel_bit;
  logic [2:0]    cur_move;
  logic          last_r;
  logic [24:0]   base_raw;
  logic [39:0]   part_hi;
  logic [38:0]   part_lo;
  logic [39:0]   diag_sum;
  logic [19:0]   diag_val;
  logic [EDGE_W-1:0] cost_val;

  logic          out_free;
  logic          load_hit;
  logic          load_empty;

  logic [COORD_W-1:0] rx;
  logic [COORD_W-1:0] ry;
  logic [COORD_W-1:0] mx;
  logic [COORD_W-1:0] my;

  // Memory
  assign waddr = AW'(q_data.x) * AW'(MAP_DIM) + AW'(q_data.y);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= q_data.cost;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    rx = cell_coord(cmd.x, CELL_DX[rd_cnt]);
    ry = cell_coord(cmd.y, CELL_DY[rd_cnt]);
    if (rx < COORD_W'(MAP_DIM) && ry < COORD_W'(MAP_DIM)) begin
      raddr = AW'(rx) * AW'(MAP_DIM) + AW'(ry);
    end else begin
      raddr = '0;
    end
  end

  // Per-move evaluation over the captured 3x3 window.
  always_comb begin
    logic [3:0]         k;
    logic [COORD_W-1:0] nx;
    logic [COORD_W-1:0] ny;
    logic [7:0]         own;
    logic [7:0]         cm;
    logic               in_map;
    for (int a = 0; a < 8; a++) begin
      k      = MOVE_CELL[a];
      nx     = cell_coord(cmd.x, CELL_DX[k]);
      ny     = cell_coord(cmd.y, CELL_DY[k]);
      in_map = (nx < COORD_W'(cfg.width)) && (ny < COORD_W'(cfg.height));
      own    = nb[k];
      cm     = cmd.succ ? own : nb[CENTER_CELL];
      if (MOVE_DIAG[a]) begin
        if (nb[ORTHO_A[a]] > cm) cm = nb[ORTHO_A[a]];
        if (nb[ORTHO_B[a]] > cm) cm = nb[ORTHO_B[a]];
      end
      lane_cm[a] = cm;
      lane_ok[a] = in_map && (own < cfg.threshold) && (cm < cfg.threshold)
                && (cmd.succ || (nb[CENTER_CELL] < cfg.threshold));
    end
  end

  // Lowest pending move
  always_comb begin
    sel = '0;
    for (int a = 7; a >= 0; a--) begin
      if (mask[a]) sel = 3'(a);
    end
    sel_bit = 8'b1 << sel;
  end

  // Edge cost from the multiplier results
  assign diag_sum = part_hi + 40'(part_lo[38:20]);
  assign diag_val = diag_sum[39:20];

  always_comb begin
    if (base_raw > 25'(COST_MAX)) begin
      cost_val = COST_MAX;
    end else if (!MOVE_DIAG[cur_move]) begin
      cost_val = base_raw[EDGE_W-1:0];
    end else if (diag_val > 20'(COST_MAX)) begin
      cost_val = COST_MAX;
    end else begin
      cost_val = diag_val[EDGE_W-1:0];
    end
  end

  assign mx = cell_coord(cmd.x, CELL_DX[MOVE_CELL[cur_move]]);
  assign my = cell_coord(cmd.y, CELL_DY[MOVE_CELL[cur_move]]);

  assign out_free = !rsp.valid || rsp.ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = (q_data.kind == CMD_EXPAND) ? ST_READ : ST_EMPTY;
        end
      end
      ST_READ:   if (rd_cnt == 4'd9) state_next = ST_EVAL;
      ST_EVAL:   state_next = (lane_ok == '0) ? ST_EMPTY : ST_PICK;
      ST_PICK:   state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_MUL_LO;
      ST_MUL_LO: state_next = ST_SEND;
      ST_SEND:   if (out_free) state_next = last_r ? ST_IDLE : ST_PICK;
      ST_EMPTY:  if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop      = (state == ST_IDLE) && q_valid;
    mem_we     = q_pop && (q_data.kind == CMD_WRITE);
    rd_issue   = (state == ST_READ) && (rd_cnt < 4'd9);
    load_hit   = (state == ST_SEND) && out_free;
    load_empty = (state == ST_EMPTY) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_cnt    <= '0;
      cap_en    <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state  <= state_next;
      cap_en <= rd_issue;
      if (q_pop) begin
        rd_cnt <= '0;
      end else if (rd_issue) begin
        rd_cnt <= rd_cnt + 4'd1;
      end
      if (load_hit || load_empty) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_data;
    end
    cap_idx <= rd_cnt;
    if (cap_en) begin
      nb[cap_idx] <= rdata;
    end
    if (state == ST_EVAL) begin
      mask <= lane_ok;
      for (int a = 0; a < 8; a++) begin
        cm_r[a] <= lane_cm[a];
      end
    end
    if (state == ST_PICK) begin
      cur_move <= sel;
      last_r   <= (mask & ~sel_bit) == '0;
      mask     <= mask & ~sel_bit;
      base_raw <= 25'({1'b0, cm_r[sel]} + 9'd1) * 25'(SCALE);
    end
    if (state == ST_MUL_HI) begin
      part_hi <= 40'(base_raw[EDGE_W-1:0]) * 40'(SQRT2_HI);
    end
    if (state == ST_MUL_LO) begin
      part_lo <= 39'(base_raw[EDGE_W-1:0]) * 39'(SQRT2_LO);
    end
    if (load_hit) begin
      rsp.neighbor_x  <= mx[7:0];
      rsp.neighbor_y  <= my[7:0];
      rsp.edge_cost   <= cost_val;
      rsp.move_index  <= cur_move;
      rsp.item_valid  <= 1'b1;
      rsp.last_of_run <= last_r;
    end else if (load_empty) begin
      rsp.neighbor_x  <= '0;
      rsp.neighbor_y  <= '0;
      rsp.edge_cost   <= '0;
      rsp.move_index  <= '0;
      rsp.item_valid  <= 1'b0;
      rsp.last_of_run <= 1'b1;
    end
  end

endmodule

`default_nettype wire

### bench/grid_neighbor_edge_expander_tb.sv
// Self-checking bench for the grid neighbor edge expander: a directed table and
// random request streams checked against an in-bench predictor of the cost grid.
// Depends on gne_pkg, gne_if and the grid_neighbor_edge_expander RTL.
`timescale 1ns / 100ps

module grid_neighbor_edge_expander_tb;
  import gne_pkg::*;

  localparam int DIM   = 256;
  localparam int SCALE = 1000;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [40:0] SQRT2_Q40 = 41'h16A09E667F4;

  typedef struct packed {
    logic [7:0]  nx;
    logic [7:0]  ny;
    logic [18:0] cost;
    logic [2:0]  mi;
    logic        iv;
    logic        last;
  } neighbor_t;

  // One row of the directed table. When has_exp is set, the predictor's first
  // result for the transfer is also compared with the typed-in value.
  typedef struct {
    mode_t     mode;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] c;
    logic       has_exp;
    neighbor_t  exp;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gne_req_if req();
  gne_rsp_if rsp();

  grid_neighbor_edge_expander u_dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Predictor copy of the grid and the settings.
  logic [7:0] grid_shadow [DIM*DIM];
  bit         grid_known  [DIM*DIM];
  int unsigned sh_width, sh_height, sh_thresh, sh_goal_x, sh_goal_y;

  neighbor_t expected_neighbors[$];
  int  first_pred = 0;
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  hold_off = 1'b0;
  bit  stim_done = 1'b0;

  // Cells already written, so random expansions only touch known neighborhoods.
  int  known_x[$];
  int  known_y[$];

  function automatic logic [18:0] scaled_edge(int unsigned c, bit diag);
    logic [63:0] base;
    base = (64'(c) + 64'd1) * 64'(SCALE);
    if (base > 64'(COST_MAX)) return COST_MAX;
    if (diag) begin
      base = (base * 64'(SQRT2_Q40)) >> 40;
      if (base > 64'(COST_MAX)) return COST_MAX;
    end
    return base[18:0];
  endfunction

  function automatic int unsigned cell_at(int x, int y);
    return grid_shadow[x*DIM + y];
  endfunction

  // Applies one request to the shadow grid and queues the results it causes.
  task automatic predict_neighbors(mode_t mode, int x, int y, logic [7:0] c);
    int dx[8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
    int dy[8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
    int w, h, n, sx, sy;
    int unsigned src, own, cm;
    bit succ, skip, diag;
    neighbor_t r;
    w = (sh_width > 256) ? 256 : sh_width;
    h = (sh_height > 256) ? 256 : sh_height;
    n = 0;
    if (mode == MODE_WRITE) begin
      grid_shadow[x*DIM + y] = c;
      grid_known[x*DIM + y] = 1'b1;
    end else if ((mode == MODE_SUCC || mode == MODE_PRED) && x < w && y < h) begin
      succ = (mode == MODE_SUCC);
      src = cell_at(x, y);
      skip = succ ? (x == sh_goal_x && y == sh_goal_y) : (src >= sh_thresh);
      if (!skip) begin
        for (int a = 0; a < 8; a++) begin
          sx = x + dx[a];
          sy = y + dy[a];
          if (sx < 0 || sy < 0 || sx >= w || sy >= h) continue;
          own = cell_at(sx, sy);
          if (own >= sh_thresh) continue;
          cm = succ ? own : src;
          diag = (sx != x) && (sy != y);
          if (diag) begin
            if (cell_at(x, sy) > cm) cm = cell_at(x, sy);
            if (cell_at(sx, y) > cm) cm = cell_at(sx, y);
          end
          if (cm >= sh_thresh) continue;
          r = '{nx: sx[7:0], ny: sy[7:0], cost: scaled_edge(cm, diag),
                mi: a[2:0], iv: 1'b1, last: 1'b0};
          expected_neighbors.insert(expected_neighbors.size(), r);
          n++;
        end
      end
    end
    if (n == 0) begin
      r = '{default: '0};
      r.last = 1'b1;
      expected_neighbors.insert(expected_neighbors.size(), r);
    end else begin
      expected_neighbors[$].last = 1'b1;
    end
  endtask

  // Result side: random stalls, the long hold-off, and the field compare.
  always @(posedge clk) begin
    neighbor_t got, want;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{nx: rsp.neighbor_x, ny: rsp.neighbor_y, cost: rsp.edge_cost,
                mi: rsp.move_index, iv: rsp.item_valid, last: rsp.last_of_run};
        if (expected_neighbors.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %p", got);
        end else begin
          want = expected_neighbors.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("Result mismatch: expected %p, got %p", want, got);
          end
        end
      end
      if (hold_off) rsp.ready <= 1'b0;
      else if ($urandom_range(0, 99) < 5) rsp.ready <= 1'b0;
      else if ($urandom_range(0, 99) < 70) rsp.ready <= 1'b1;
    end
  end

  // The watchdog counts cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sends one request and waits for its transfer. The expectation is made at
  // the transfer edge, so writes and expansions see the grid in program order.
  task automatic send_request(mode_t mode, logic [7:0] x, logic [7:0] y, logic [7:0] c);
    req.valid <= 1'b1;
    req.mode <= mode;
    req.cell_x <= x;
    req.cell_y <= y;
    req.cell_cost <= c;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    first_pred = expected_neighbors.size();
    predict_neighbors(mode, x, y, c);
    if (mode == MODE_WRITE) begin
      known_x.insert(known_x.size(), int'(x));
      known_y.insert(known_y.size(), int'(y));
    end
  endtask

  // Occasional gaps between transfers: mostly short, a few long.
  task automatic sender_gap();
    int g;
    if ($urandom_range(0, 99) < 60) return;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
    req.valid <= 1'b0;
    repeat (g) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MAP_WIDTH:  sh_width = value;
      CFG_MAP_HEIGHT: sh_height = value;
      CFG_THRESHOLD:  sh_thresh = value;
      CFG_GOAL_X:     sh_goal_x = value;
      default:        sh_goal_y = value;
    endcase
  endtask

  // Drains every outstanding result, then waits out the back end's latency.
  task automatic wait_idle();
    req.valid <= 1'b0;
    while (expected_neighbors.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_config(int w, int h, int t, int gx, int gy);
    wait_idle();
    write_reg(CFG_MAP_WIDTH, w);
    write_reg(CFG_MAP_HEIGHT, h);
    write_reg(CFG_THRESHOLD, t);
    write_reg(CFG_GOAL_X, gx);
    write_reg(CFG_GOAL_Y, gy);
  endtask

  // Writes a random 3x3 patch around (x, y), then expands it once or twice,
  // so most random traffic reaches the neighbor evaluation with real content.
  task automatic random_patch(int x, int y, int max_cost);
    int k;
    mode_t m;
    for (int i = -1; i <= 1; i++)
      for (int j = -1; j <= 1; j++)
        if (x + i >= 0 && y + j >= 0 && x + i < DIM && y + j < DIM) begin
          send_request(MODE_WRITE, 8'(x + i), 8'(y + j), 8'($urandom_range(0, max_cost)));
          sender_gap();
        end
    k = $urandom_range(1, 2);
    repeat (k) begin
      m = $urandom_range(0, 1) ? MODE_SUCC : MODE_PRED;
      send_request(m, 8'(x), 8'(y), 8'($urandom));
      sender_gap();
    end
  endtask

  row_t directed [];
  int   px, py, pick;

  initial begin
    req.valid = 1'b0;
    req.mode = MODE_WRITE;
    req.cell_x = '0;
    req.cell_y = '0;
    req.cell_cost = '0;
    sh_width = 256; sh_height = 256; sh_thresh = 1; sh_goal_x = 0; sh_goal_y = 0;
    foreach (grid_shadow[i]) grid_shadow[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings first: threshold 1 means only zero-cost cells are open.
    // Corners and edges of the full map, writes at the extremes of the cost
    // field, goal in successor mode, obstacle source in predecessor mode.
    // Every expanded cell has its whole 3x3 window written beforehand.
    directed = '{
      '{MODE_WRITE, 8'd0,   8'd0,   8'd0,   1'b1, '{default: '0, last: 1'b1}},
      '{MODE_WRITE, 8'd1,   8'd0,   8'd0,   1'b1, '{default: '0, last: 1'b1}},
      '{MODE_WRITE, 8'd0,   8'd1,   8'd0,   1'b0, '{default: '0}},
      '{MODE_WRITE, 8'd1,   8'd1,   8'd255, 1'b0, '{default: '0}},
      '{MODE_SUCC,  8'd0,   8'd0,   8'd0,   1'b1, '{default: '0, last: 1'b1}},
      '{MODE_PRED,  8'd0,   8'd0,   8'd170, 1'b1,
        '{nx: 8'd0, ny: 8'd1, cost: 19'd1000, mi: 3'd4, iv: 1'b1, last: 1'b0}},
      '{MODE_WRITE, 8'd2,   8'd0,   8'd0,   1'b0, '{default: '0}},
      '{MODE_WRITE, 8'd2,   8'd1,   8'd0,   1'b0, '{default: '0}},
      '{MODE_WRITE, 8'd2,   8'd2,   8'd0,   1'b0, '{default: '0}},
      '{MODE_WRITE, 8'd0,   8'd2,   8'd0,   1'b0, '{default: '0}},
      '{MODE_WRITE, 8'd1,   8'd2,   8'd0,   1'b0, '{default: '0}},
      '{MODE_PRED,  8'd1,   8'd1,   8'd0,   1'b1, '{default: '0, last: 1'b1}},
      '{MODE_SUCC,  8'd1,   8'd0,   8'd0,   1'b0, '{default: '0}},
      '{MODE_NONE,  8'd255, 8'd255, 8'd255, 1'b1, '{default: '0, last: 1'b1}},
      '{MODE_WRITE, 8'd255, 8'd255, 8'd0,   1'b0, '{default: '0}},
      '{MODE_WRITE, 8'd254, 8'd255, 8'd0,   1'b0, '{default: '0}},
      '{MODE_WRITE, 8'd255, 8'd254, 8'd0,   1'b0, '{default: '0}},
      '{MODE_WRITE, 8'd254, 8'd254, 8'd0,   1'b0, '{default: '0}},
      '{MODE_WRITE, 8'd253, 8'd253, 8'd0,   1'b0, '{default: '0}},
      '{MODE_WRITE, 8'd253, 8'd254, 8'd0,   1'b0, '{default: '0}},
      '{MODE_WRITE, 8'd253, 8'd255, 8'd0,   1'b0, '{default: '0}},
      '{MODE_WRITE, 8'd254, 8'd253, 8'd0,   1'b0, '{default: '0}},
      '{MODE_WRITE, 8'd255, 8'd253, 8'd0,   1'b0, '{default: '0}},
      '{MODE_SUCC,  8'd255, 8'd255, 8'd85,  1'b0, '{default: '0}},
      '{MODE_PRED,  8'd254, 8'd254, 8'd0,   1'b0, '{default: '0}},
      '{MODE_WRITE, 8'd0,   8'd255, 8'd0,   1'b0, '{default: '0}},
      '{MODE_WRITE, 8'd1,   8'd255, 8'd0,   1'b0, '{default: '0}},
      '{MODE_WRITE, 8'd0,   8'd254, 8'd0,   1'b0, '{default: '0}},
      '{MODE_WRITE, 8'd1,   8'd254, 8'd0,   1'b0, '{default: '0}},
      '{MODE_SUCC,  8'd0,   8'd255, 8'd0,   1'b0, '{default: '0}}
    };
    foreach (directed[i]) begin
      send_request(directed[i].mode, directed[i].x, directed[i].y, directed[i].c);
      if (directed[i].has_exp && expected_neighbors[first_pred] !== directed[i].exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Table row %0d: expected %p, predicted %p", i,
                   directed[i].exp, expected_neighbors[first_pred]);
      end
      sender_gap();
    end

    // Threshold 255 with costs near 254 drives the edge cost toward the top
    // of its range; a small map then cuts neighbors off at its right edge.
    set_config(256, 256, 255, 255, 255);
    random_patch(100, 100, 254);
    random_patch(0, 0, 254);
    random_patch(255, 255, 254);
    set_config(1, 1, 0, 0, 0);
    send_request(MODE_SUCC, 8'd0, 8'd0, 8'd0);
    send_request(MODE_PRED, 8'd0, 8'd0, 8'd0);
    set_config(1, 256, 255, 0, 0);
    send_request(MODE_SUCC, 8'd0, 8'd1, 8'd0);
    send_request(MODE_SUCC, 8'd1, 8'd1, 8'd0);
    set_config(511, 300, 200, 100, 100);
    send_request(MODE_SUCC, 8'd100, 8'd100, 8'd0);
    random_patch(101, 101, 255);

    // Long receiver hold-off while requests keep coming, so the queue fills.
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        random_patch(30, 30, 200);
      end
    join

    // Random phases under several settings, mixing well-formed patches with
    // loose requests to known cells and an occasional unused mode.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_config(256, 256, 128, $urandom_range(0, 255), $urandom_range(0, 255));
        1: set_config($urandom_range(2, 40), $urandom_range(2, 40), $urandom_range(1, 255),
                      $urandom_range(0, 40), $urandom_range(0, 40));
        2: set_config(256, 256, 255, 10, 10);
        default: set_config(256, 256, $urandom_range(0, 255), 0, 0);
      endcase
      repeat (3) begin
        if (phase == 1) random_patch($urandom_range(0, 40), $urandom_range(0, 40), 255);
        else random_patch($urandom_range(0, 255), $urandom_range(0, 255), 255);
      end
      repeat (5) begin
        pick = $urandom_range(0, known_x.size() - 1);
        px = known_x[pick];
        py = known_y[pick];
        // Expanding a written cell reads its 3x3 window; stay only where the
        // whole window is known.
        if ($urandom_range(0, 9) == 0) begin
          send_request(MODE_NONE, 8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          bit all_known;
          all_known = 1'b1;
          for (int i = -1; i <= 1; i++)
            for (int j = -1; j <= 1; j++)
              if (px + i >= 0 && py + j >= 0 && px + i < DIM && py + j < DIM)
                if (!grid_known[(px + i)*DIM + py + j]) all_known = 1'b0;
          if (all_known)
            send_request($urandom_range(0, 1) ? MODE_SUCC : MODE_PRED, 8'(px), 8'(py), 8'd0);
          else
            send_request(MODE_WRITE, 8'(px), 8'(py), 8'($urandom));
        end
        sender_gap();
      end
    end

    wait_idle();
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Any expectation still open when the run ends is a failure; it is caught
  // above because wait_idle only returns once the store is empty, and the
  // watchdog ends the run if results stop arriving.

endmodule
